/* src/fat_pkg.sv */
// Shared types and constants for the fully associative TLB with LRU replacement.
// Item structs, the queued job record, back-end states and configuration codes.
// No dependencies.
package fat_pkg;

  localparam int ADDR_W        = 32;  // width of the address fields
  localparam int CFG_W         = 5;   // widest configuration register
  localparam int CFG_IDX_W     = 1;   // register index width
  localparam int OFS_MIN       = 4;
  localparam int OFS_MAX       = 20;
  localparam int OFS_RESET     = 12;
  localparam int SLOTS_RESET   = 16;
  localparam int PAGE_MAX_W    = ADDR_W - OFS_MIN;
  localparam int STAMP_W       = 32;
  localparam int CNT_W         = 32;
  localparam int Q_DEPTH       = 2;
  localparam int QP_W          = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W          = $clog2(Q_DEPTH + 1);

  localparam int ENTRIES_DEF   = 16;
  localparam int ADDR_BITS_DEF = 32;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS  = 1'b1;

  typedef enum logic [1:0] {
    CMD_XLATE = 2'd0,
    CMD_FILL  = 2'd1,
    CMD_INVAL = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_SCAN,
    BK_INSTALL
  } back_state_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] virtual_address;
    logic [ADDR_W-1:0] physical_address;
    logic              walk_hit;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    logic              tlb_hit;
    logic              table_hit;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  miss_total;
  } out_item_t;

  // Decoded item as queued between front and back end.
  typedef struct packed {
    cmd_t                  op;
    logic [ADDR_W-1:0]     vaddr;    // masked
    logic [ADDR_W-1:0]     paddr;    // masked
    logic [PAGE_MAX_W-1:0] vpage;
    logic [PAGE_MAX_W-1:0] ppage;
    logic                  walk_hit;
    logic [CFG_W-1:0]      ofs;      // clamped offset width
    logic [CFG_W-1:0]      slots;    // clamped slot count
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* src/fully_assoc_tlb_lru_top.sv */
// Flow: an accepted item is queued, popped into the job register, then matched,
//   updated and registered as the result; a fill into a full table first runs the
//   LRU scan and install, the scan reading one age stamp per cycle from stamp memory.
// The back end holds one job at a time and pops the next only after emitting a result.
// Reset (rst, synchronous): clears valid bits, access clock, counters and queue; the
//   offset width returns to 12 and the slot count to 16. Entry contents are not cleared.
module fully_assoc_tlb_lru_top #(
  parameter int ENTRIES   = fat_pkg::ENTRIES_DEF,
  parameter int ADDR_BITS = fat_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [fat_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [fat_pkg::CFG_W-1:0]     cfg_data,
  // item in
  input  logic                          req_valid,
  output logic                          req_ready,
  input  fat_pkg::in_item_t             req,
  // result out
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output fat_pkg::out_item_t            rsp
);
  import fat_pkg::*;

  job_t    fe_job, q_head;
  q_stat_t qs;
  logic    push, pop;

  // Front end: takes an item whenever the queue has room, clamps the
  // configuration and splits addresses into page and offset.
  fat_front #(
    .ENTRIES   (ENTRIES),
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .qs        (qs),
    .push      (push),
    .job       (fe_job)
  );

  // Two-deep job queue decouples acceptance from execution.
  fat_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (fe_job),
    .pop    (pop),
    .head   (q_head),
    .qs     (qs)
  );

  // Back end: parallel tag match, install/evict, counters and the
  // result register, which holds a result while the next job is fetched.
  fat_back #(
    .ENTRIES   (ENTRIES),
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .qs        (qs),
    .head      (q_head),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

/* src/fat_front.sv */
// Front end: configuration registers, item acceptance and decode into a job.
// Depends on fat_pkg.
module fat_front #(
  parameter int ENTRIES   = fat_pkg::ENTRIES_DEF,
  parameter int ADDR_BITS = fat_pkg::ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fat_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [fat_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  fat_pkg::in_item_t              req,
  input  fat_pkg::q_stat_t               qs,
  output logic                           push,
  output fat_pkg::job_t                  job
);
  import fat_pkg::*;

  localparam int AW_EFF = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam logic [ADDR_W-1:0] AMASK = {ADDR_W{1'b1}} >> (ADDR_W - AW_EFF);

  logic [CFG_W-1:0]  ofs_reg, slots_reg;
  logic [CFG_W-1:0]  ofs, slots;
  logic [ADDR_W-1:0] va_m, pa_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      ofs_reg   <= CFG_W'(OFS_RESET);
      slots_reg <= CFG_W'(SLOTS_RESET);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_OFFSET: ofs_reg   <= cfg_data;
        REG_SLOTS:  slots_reg <= cfg_data;
      endcase
    end
  end

  // clamp to the supported ranges
  always_comb begin
    ofs = ofs_reg;
    if (ofs_reg < CFG_W'(OFS_MIN)) ofs = CFG_W'(OFS_MIN);
    else if (ofs_reg > CFG_W'(OFS_MAX)) ofs = CFG_W'(OFS_MAX);
    slots = slots_reg;
    if (slots_reg == '0) slots = CFG_W'(1);
    else if (int'(slots_reg) > ENTRIES) slots = CFG_W'(ENTRIES);
  end

  assign va_m      = req.virtual_address & AMASK;
  assign pa_m      = req.physical_address & AMASK;
  assign req_ready = !qs.full;
  assign push      = req_valid && req_ready;

  always_comb begin
    job.op       = cmd_t'(req.command);
    job.vaddr    = va_m;
    job.paddr    = pa_m;
    job.vpage    = PAGE_MAX_W'(va_m >> ofs);
    job.ppage    = PAGE_MAX_W'(pa_m >> ofs);
    job.walk_hit = req.walk_hit;
    job.ofs      = ofs;
    job.slots    = slots;
  end

endmodule

/* src/fat_queue.sv */
// Short job queue between front and back end.
// Depends on fat_pkg.
module fat_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  fat_pkg::job_t    wr_job,
  input  logic             pop,
  output fat_pkg::job_t    head,
  output fat_pkg::q_stat_t qs
);
  import fat_pkg::*;

  job_t             slot_q [Q_DEPTH];
  logic [QP_W-1:0]  wr_ptr, rd_ptr;
  logic [QC_W-1:0]  count;

  assign head     = slot_q[rd_ptr];
  assign qs.full  = (int'(count) == Q_DEPTH);
  assign qs.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (int'(wr_ptr) == Q_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (int'(rd_ptr) == Q_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_q[wr_ptr] <= wr_job;
  end

endmodule

/* src/fat_back.sv */
// Back end: entry table, match logic, LRU victim scan, counters, result register.
// Depends on fat_pkg.
module fat_back #(
  parameter int ENTRIES   = fat_pkg::ENTRIES_DEF,
  parameter int ADDR_BITS = fat_pkg::ADDR_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  fat_pkg::q_stat_t   qs,
  input  fat_pkg::job_t      head,
  output logic               pop,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output fat_pkg::out_item_t rsp
);
  import fat_pkg::*;

  localparam int AW_EFF = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int PAGE_W = AW_EFF - OFS_MIN;
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SCN_W  = $clog2(ENTRIES + 1);

  // entry table
  logic [ENTRIES-1:0]  valid;
  logic [PAGE_W-1:0]   vpage_q [ENTRIES];
  logic [PAGE_W-1:0]   ppage_q [ENTRIES];
  logic [STAMP_W-1:0]  stamp_mem [ENTRIES];
  logic [STAMP_W-1:0]  stamp_rd;

  logic [STAMP_W-1:0]  clk_cnt, clk_next;
  logic [CNT_W-1:0]    hits, hits_next, misses, misses_next;

  back_state_t         state, state_next;
  job_t                job;

  // victim scan
  logic [SCN_W-1:0]    scan_idx;
  logic                cmp_vld;
  logic [IDX_W-1:0]    cmp_idx, victim;
  logic [STAMP_W-1:0]  best_age, age;
  logic                scan_start, scan_issue, scan_done;

  logic [ENTRIES-1:0]  inuse, vmatch, pmatch, free, vfirst, pfirst, ffirst;
  logic [IDX_W-1:0]    hit_idx, inv_idx, free_idx, ins_slot;
  logic [PAGE_W-1:0]   ppage_sel;
  logic                vhit_any, phit_any, free_any;
  logic [AW_EFF-1:0]   xl_addr;

  logic                rsp_free, emit;
  logic                hit_now, miss_now, fill_now, inval_now;
  out_item_t           rsp_next;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      inuse[i]  = i < int'(job.slots);
      vmatch[i] = inuse[i] && valid[i] && (vpage_q[i] == job.vpage[PAGE_W-1:0]);
      pmatch[i] = inuse[i] && valid[i] && (ppage_q[i] == job.ppage[PAGE_W-1:0]);
      free[i]   = inuse[i] && !valid[i];
    end
  end

  // lowest set bit of each vector
  assign vfirst = vmatch & (~vmatch + ENTRIES'(1));
  assign pfirst = pmatch & (~pmatch + ENTRIES'(1));
  assign ffirst = free & (~free + ENTRIES'(1));
  assign vhit_any = |vmatch;
  assign phit_any = |pmatch;
  assign free_any = |free;

  always_comb begin
    hit_idx   = '0;
    inv_idx   = '0;
    free_idx  = '0;
    ppage_sel = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (vfirst[i]) begin
        hit_idx   = hit_idx | IDX_W'(i);
        ppage_sel = ppage_sel | ppage_q[i];
      end
      if (pfirst[i]) inv_idx = inv_idx | IDX_W'(i);
      if (ffirst[i]) free_idx = free_idx | IDX_W'(i);
    end
  end

  assign xl_addr = (AW_EFF'(ppage_sel) << job.ofs)
                 | (job.vaddr[AW_EFF-1:0] & ~({AW_EFF{1'b1}} << job.ofs));

  assign rsp_free   = !rsp_valid || rsp_ready;
  assign scan_issue = (state == BK_SCAN) && (int'(scan_idx) < int'(job.slots));
  assign scan_done  = (state == BK_SCAN) && !scan_issue && !cmp_vld;
  assign age        = clk_cnt - stamp_rd;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    emit       = 1'b0;
    scan_start = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!qs.empty) begin
          pop        = 1'b1;
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (job.op == CMD_FILL && !free_any) begin
          scan_start = 1'b1;
          state_next = BK_SCAN;
        end else if (rsp_free) begin
          emit       = 1'b1;
          state_next = BK_IDLE;
        end
      end
      BK_SCAN: begin
        if (scan_done) state_next = BK_INSTALL;
      end
      BK_INSTALL: begin
        if (rsp_free) begin
          emit       = 1'b1;
          state_next = BK_IDLE;
        end
      end
    endcase
  end

  assign hit_now   = emit && job.op == CMD_XLATE && vhit_any;
  assign miss_now  = emit && job.op == CMD_XLATE && !vhit_any;
  assign fill_now  = emit && job.op == CMD_FILL;
  assign inval_now = emit && job.op == CMD_INVAL && phit_any;
  // a full table installs into the LRU victim's slot, otherwise the lowest free slot
  assign ins_slot  = (state == BK_INSTALL) ? victim : free_idx;

  always_comb begin
    hits_next   = (hit_now && hits != {CNT_W{1'b1}}) ? hits + 1'b1 : hits;
    misses_next = (miss_now && misses != {CNT_W{1'b1}}) ? misses + 1'b1 : misses;
    clk_next    = (hit_now || fill_now) ? clk_cnt + 1'b1 : clk_cnt;

    rsp_next.result_address = '0;
    if (hit_now) rsp_next.result_address = ADDR_W'(xl_addr);
    else if (job.op == CMD_FILL) rsp_next.result_address = job.paddr;
    rsp_next.tlb_hit    = hit_now;
    rsp_next.table_hit  = (job.op == CMD_FILL) ? job.walk_hit : 1'b0;
    rsp_next.hit_total  = hits_next;
    rsp_next.miss_total = misses_next;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      clk_cnt   <= '0;
      hits      <= '0;
      misses    <= '0;
      rsp_valid <= 1'b0;
      cmp_vld   <= 1'b0;
    end else begin
      if (emit)           rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      hits    <= hits_next;
      misses  <= misses_next;
      clk_cnt <= clk_next;
      if (inval_now) valid[inv_idx]  <= 1'b0;
      if (fill_now)  valid[ins_slot] <= 1'b1;
      cmp_vld <= scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (pop)  job <= head;
    if (emit) rsp <= rsp_next;
    if (fill_now) begin
      vpage_q[ins_slot] <= job.vpage[PAGE_W-1:0];
      ppage_q[ins_slot] <= job.ppage[PAGE_W-1:0];
    end
    if (scan_start)      scan_idx <= '0;
    else if (scan_issue) scan_idx <= scan_idx + 1'b1;
    if (scan_issue) cmp_idx <= scan_idx[IDX_W-1:0];
    if (cmp_vld && (cmp_idx == '0 || age > best_age)) begin
      best_age <= age;
      victim   <= cmp_idx;
    end
  end

  // stamp memory: one write port, one registered read port for the scan
  always_ff @(posedge clk) begin
    if (hit_now)       stamp_mem[hit_idx]  <= clk_cnt + 1'b1;
    else if (fill_now) stamp_mem[ins_slot] <= clk_cnt + 1'b1;
    stamp_rd <= stamp_mem[scan_idx[IDX_W-1:0]];
  end

  ap_victim_in_use: assert property (@(posedge clk) disable iff (rst)
    state == BK_INSTALL |-> valid[victim] && (int'(victim) < int'(job.slots)))
    else $error("LRU victim is not a valid slot in use");

  ap_fill_sets_valid: assert property (@(posedge clk) disable iff (rst)
    fill_now |=> valid[$past(ins_slot)])
    else $error("filled slot not valid afterwards");

  ap_hits_monotone: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> hits >= $past(hits))
    else $error("hit counter went backwards");

  ap_clock_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && clk_cnt != $past(clk_cnt) |-> $past(hit_now || fill_now))
    else $error("access clock moved without a hit or fill");

endmodule

/* bench/fully_assoc_tlb_lru_top_tb.sv */
// Self-checking bench for fully_assoc_tlb_lru_top: a directed table, then random phases under
// several register settings; each result is checked against a hand-written or a model value.
// Depends on fat_pkg and the RTL of fully_assoc_tlb_lru_top.
module fully_assoc_tlb_lru_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fat_pkg::*;

  localparam int SLOT_MAX        = ENTRIES_DEF;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int FRAME_POOL      = 24;   // a little over the table size, so LRU gets exercised
  localparam int PHASES          = 8;
  localparam int LONG_HOLD       = 150;  // cycles of result back-pressure, once per run
  localparam int HOLD_AFTER      = 380;  // results checked before the long hold-off starts
  localparam int TAIL_CYCLES     = 40;

  // Register settings per random phase; out-of-range values included on purpose.
  localparam logic [CFG_W-1:0] PHASE_OFS   [PHASES] =
    '{5'd4, 5'd20, 5'd12, 5'd3, 5'd21, 5'd7, 5'd16, 5'd12};
  localparam logic [CFG_W-1:0] PHASE_SLOTS [PHASES] =
    '{5'd16, 5'd1, 5'd8, 5'd17, 5'd31, 5'd3, 5'd0, 5'd16};

  typedef enum logic {ROW_ITEM, ROW_SETUP} row_kind_t;

  // One line of the directed table: either an item or a pair of register writes.
  typedef struct packed {
    row_kind_t        kind;
    in_item_t         item;
    logic             typed;   // want holds a hand-written expectation
    out_item_t        want;
    logic [CFG_W-1:0] ofs;
    logic [CFG_W-1:0] slots;
  } row_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = REG_OFFSET;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  in_item_t             req       = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  out_item_t            rsp;

  always #4 clk = ~clk;

  fully_assoc_tlb_lru_top DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  // ---------------------------------------------------------------------------
  // TLB model: the bench's own copy of registers, table and counters.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]      ofs_reg;
  logic [CFG_W-1:0]      slots_reg;
  logic                  ent_valid [SLOT_MAX];
  logic [PAGE_MAX_W-1:0] ent_vpage [SLOT_MAX];
  logic [PAGE_MAX_W-1:0] ent_ppage [SLOT_MAX];
  logic [STAMP_W-1:0]    ent_stamp [SLOT_MAX];
  logic [STAMP_W-1:0]    access_ticks;
  logic [CNT_W-1:0]      hit_count;
  logic [CNT_W-1:0]      miss_count;

  out_item_t   pending_results [$];   // expected results, oldest first
  int unsigned mismatches       = 0;
  int unsigned results_seen     = 0;
  int unsigned items_sent       = 0;
  int unsigned fill_count       = 0;
  int unsigned settings_applied = 0;
  int unsigned send_gap_pct     = 0;  // chance of a sender gap before each item
  int unsigned take_gap_pct     = 0;  // chance of a receiver stall each cycle

  logic [ADDR_W-1:0] vframes [FRAME_POOL];
  logic [ADDR_W-1:0] pframes [FRAME_POOL];

  function automatic void tlb_reset_state();
    ofs_reg      = CFG_W'(OFS_RESET);
    slots_reg    = CFG_W'(SLOTS_RESET);
    access_ticks = '0;
    hit_count    = '0;
    miss_count   = '0;
    for (int i = 0; i < SLOT_MAX; i++) begin
      ent_valid[i] = 1'b0;
      ent_vpage[i] = '0;
      ent_ppage[i] = '0;
      ent_stamp[i] = '0;
    end
  endfunction

  // Offset width and slot count as the block uses them, clamped into range.
  function automatic int unsigned page_shift();
    if (ofs_reg < OFS_MIN) return OFS_MIN;
    if (ofs_reg > OFS_MAX) return OFS_MAX;
    return ofs_reg;
  endfunction

  function automatic int unsigned live_slots();
    if (slots_reg == 0) return 1;
    if (slots_reg > SLOT_MAX) return SLOT_MAX;
    return slots_reg;
  endfunction

  function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // Applies one item to the model and returns the result it should produce.
  function automatic out_item_t tlb_predict(in_item_t it);
    int unsigned           sh;
    int unsigned           n;
    int unsigned           used;
    int unsigned           victim;
    int unsigned           slot;
    logic [STAMP_W-1:0]    age;
    logic [STAMP_W-1:0]    oldest;
    logic [PAGE_MAX_W-1:0] vp;
    logic [PAGE_MAX_W-1:0] pp;
    bit                    found;
    out_item_t             o;
    sh    = page_shift();
    n     = live_slots();
    vp    = PAGE_MAX_W'(it.virtual_address >> sh);
    pp    = PAGE_MAX_W'(it.physical_address >> sh);
    o     = '0;
    found = 1'b0;
    case (cmd_t'(it.command))
      CMD_XLATE: begin
        // lowest matching slot wins when a page is installed twice
        for (int i = 0; i < n && !found; i++) begin
          if (ent_valid[i] && ent_vpage[i] == vp) begin
            found        = 1'b1;
            hit_count    = bump(hit_count);
            access_ticks = access_ticks + 1'b1;
            ent_stamp[i] = access_ticks;
            o.result_address = ADDR_W'((64'(ent_ppage[i]) << sh) |
                                       (64'(it.virtual_address) & ((64'd1 << sh) - 1)));
            o.tlb_hit = 1'b1;
          end
        end
        if (!found) miss_count = bump(miss_count);
      end
      CMD_FILL: begin
        o.result_address = it.physical_address;
        o.table_hit      = it.walk_hit;
        used = 0;
        for (int i = 0; i < n; i++) used += ent_valid[i];
        if (used == n) begin
          // evict the oldest by wrapped age; ties go to the lower slot
          victim = 0;
          oldest = '0;
          for (int i = 0; i < n; i++) begin
            age = access_ticks - ent_stamp[i];
            if (i == 0 || age > oldest) begin
              oldest = age;
              victim = i;
            end
          end
          ent_valid[victim] = 1'b0;
        end
        slot = n;
        for (int i = 0; i < n; i++) if (!ent_valid[i] && slot == n) slot = i;
        if (slot < n) begin
          access_ticks    = access_ticks + 1'b1;
          ent_valid[slot] = 1'b1;
          ent_vpage[slot] = vp;
          ent_ppage[slot] = pp;
          ent_stamp[slot] = access_ticks;
        end
        fill_count++;
      end
      CMD_INVAL: begin
        for (int i = 0; i < n && !found; i++) begin
          if (ent_valid[i] && ent_ppage[i] == pp) begin
            ent_valid[i] = 1'b0;
            found        = 1'b1;
          end
        end
      end
      default: ;
    endcase
    o.hit_total  = hit_count;
    o.miss_total = miss_count;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table builders
  // ---------------------------------------------------------------------------
  function automatic in_item_t make_item(cmd_t c, logic [ADDR_W-1:0] va,
                                         logic [ADDR_W-1:0] pa, logic wh);
    in_item_t it;
    it.command          = c;
    it.virtual_address  = va;
    it.physical_address = pa;
    it.walk_hit         = wh;
    return it;
  endfunction

  function automatic row_t row_of(cmd_t c, logic [ADDR_W-1:0] va,
                                  logic [ADDR_W-1:0] pa, logic wh);
    row_t r;
    r      = '0;
    r.kind = ROW_ITEM;
    r.item = make_item(c, va, pa, wh);
    return r;
  endfunction

  function automatic row_t row_want(cmd_t c, logic [ADDR_W-1:0] va, logic [ADDR_W-1:0] pa,
                                    logic wh, logic [ADDR_W-1:0] res, logic th, logic wt,
                                    logic [CNT_W-1:0] hits, logic [CNT_W-1:0] misses);
    row_t r;
    r       = row_of(c, va, pa, wh);
    r.typed = 1'b1;
    r.want  = '{result_address: res, tlb_hit: th, table_hit: wt,
                hit_total: hits, miss_total: misses};
    return r;
  endfunction

  function automatic row_t row_setup(logic [CFG_W-1:0] ofs, logic [CFG_W-1:0] slots);
    row_t r;
    r       = '0;
    r.kind  = ROW_SETUP;
    r.ofs   = ofs;
    r.slots = slots;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offers one item, holds it until taken, then records what should come back.
  task automatic offer(in_item_t it, bit typed, out_item_t want);
    out_item_t guess;
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req       <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    guess = tlb_predict(it);
    pending_results.push_back(typed ? want : guess);
    items_sent++;
  endtask

  // Drains the block, then writes both registers. Every item yields a result,
  // so an empty expectation queue means nothing is left in flight.
  task automatic settle_and_configure(logic [CFG_W-1:0] ofs, logic [CFG_W-1:0] slots);
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_OFFSET;
    cfg_data <= ofs;
    @(posedge clk);
    ofs_reg = ofs;
    cfg_idx  <= REG_SLOTS;
    cfg_data <= slots;
    @(posedge clk);
    slots_reg = slots;
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // Random traffic, mostly lookups on a small set of pages, each lookup often
  // followed by the refill a miss would cause; the rest is stray fills,
  // shoot-downs and the unused command.
  task automatic random_phase(int unsigned count);
    int unsigned       made;
    int unsigned       pick;
    int unsigned       span;
    logic [ADDR_W-1:0] low;
    logic [ADDR_W-1:0] va;
    logic [ADDR_W-1:0] pa;
    made = 0;
    span = $urandom_range(4, FRAME_POOL);  // small spans hit, large ones thrash
    while (made < count) begin
      low  = ADDR_W'((64'd1 << page_shift()) - 1);
      va   = (vframes[$urandom_range(0, span - 1)] & ~low) | ($urandom & low);
      pa   = (pframes[$urandom_range(0, span - 1)] & ~low) | ($urandom & low);
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0) vframes[$urandom_range(0, FRAME_POOL - 1)] = $urandom;
      if (pick < 70) begin
        if (pick >= 58) va = $urandom;
        offer(make_item(CMD_XLATE, va, $urandom, 1'($urandom)), 1'b0, '0);
        made++;
        if ($urandom_range(0, 1) == 1) begin
          offer(make_item(CMD_FILL, va, pa, 1'($urandom)), 1'b0, '0);
          made++;
        end
      end else if (pick < 80) begin
        offer(make_item(CMD_FILL, $urandom, ($urandom_range(0, 1) == 1) ? pa : $urandom,
                        1'($urandom)), 1'b0, '0);
        made++;
      end else if (pick < 95) begin
        offer(make_item(CMD_INVAL, $urandom,
                        ($urandom_range(0, 3) == 0) ? $urandom : pa, 1'($urandom)), 1'b0, '0);
        made++;
      end else begin
        offer(make_item(CMD_RSVD, $urandom, $urandom, 1'($urandom)), 1'b0, '0);
        made++;
      end
    end
  endtask

  initial begin : drive_items
    row_t plan [$];
    tlb_reset_state();
    for (int i = 0; i < FRAME_POOL; i++) begin
      vframes[i] = $urandom;
      pframes[i] = $urandom;
    end

    // Offset 12, 16 slots after reset. Hand-written rows are the obvious ones:
    // misses on an empty table, echoed fills, simple hits, a shoot-down.
    plan = '{
      row_want(CMD_XLATE, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 1'b0, 1'b0, 0, 1),
      row_want(CMD_XLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, 1'b0, 0, 2),
      row_want(CMD_FILL,  32'h1234_5678, 32'hFFFF_F000, 1'b1, 32'hFFFF_F000, 1'b0, 1'b1, 0, 2),
      row_want(CMD_XLATE, 32'h1234_5ABC, 32'h0000_0000, 1'b0, 32'hFFFF_FABC, 1'b1, 1'b0, 1, 2),
      row_want(CMD_FILL,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0, 1'b0, 1'b0, 1, 2),
      row_want(CMD_XLATE, 32'hFFFF_F123, 32'h0000_0000, 1'b0, 32'h0000_0123, 1'b1, 1'b0, 2, 2),
      row_want(CMD_INVAL, 32'h0000_0000, 32'hFFFF_F555, 1'b0, 32'h0, 1'b0, 1'b0, 2, 2),
      row_want(CMD_XLATE, 32'h1234_5000, 32'h0000_0000, 1'b0, 32'h0, 1'b0, 1'b0, 2, 3),
      // shoot-down of a page nobody holds
      row_want(CMD_INVAL, 32'h0000_0000, 32'h0ABC_D000, 1'b0, 32'h0, 1'b0, 1'b0, 2, 3),
      // unused command: nothing moves, counters echoed
      row_want(CMD_RSVD,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, 1'b0, 2, 3),
      // fill of a page already present, then lookup picks the lower slot
      row_want(CMD_FILL,  32'hFFFF_F000, 32'h5555_5000, 1'b1, 32'h5555_5000, 1'b0, 1'b1, 2, 3),
      row_of(CMD_XLATE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0),
      // two slots, both full: fills now evict by age
      row_setup(5'd12, 5'd2),
      row_of(CMD_FILL,  32'hAAAA_A000, 32'h1111_1000, 1'b0),
      row_of(CMD_XLATE, 32'hFFFF_F000, 32'h0000_0000, 1'b0),
      row_of(CMD_XLATE, 32'hAAAA_A000, 32'h0000_0000, 1'b0),
      row_of(CMD_FILL,  32'h0000_1000, 32'h2222_2000, 1'b1),
      row_of(CMD_XLATE, 32'hAAAA_A000, 32'h0000_0000, 1'b0),
      row_of(CMD_XLATE, 32'hFFFF_F000, 32'h0000_0000, 1'b0),
      // zero in both registers: narrowest offset, a single slot
      row_setup(5'd0, 5'd0),
      row_of(CMD_FILL,  32'h0000_001F, 32'hFFFF_FFF0, 1'b1),
      row_of(CMD_XLATE, 32'h0000_001A, 32'h0000_0000, 1'b0),
      row_of(CMD_FILL,  32'h0000_002F, 32'h1234_5670, 1'b0),
      row_of(CMD_XLATE, 32'h0000_001A, 32'h0000_0000, 1'b0),
      // all ones in both registers: widest offset, every slot
      row_setup(5'd31, 5'd31),
      row_of(CMD_XLATE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0),
      row_of(CMD_FILL,  32'hFFFF_FFFF, 32'hABCD_EFFF, 1'b1),
      row_of(CMD_XLATE, 32'hFFF0_0000, 32'h0000_0000, 1'b0)
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_SETUP) settle_and_configure(plan[k].ofs, plan[k].slots);
      else offer(plan[k].item, plan[k].typed, plan[k].want);
    end

    // Random phases; the last one runs flat out on both sides.
    for (int p = 0; p < PHASES; p++) begin
      settle_and_configure(PHASE_OFS[p], PHASE_SLOTS[p]);
      send_gap_pct = (p == PHASES - 1) ? 0 : 20 * $urandom_range(0, 2);
      take_gap_pct = (p == PHASES - 1) ? 0 : 20 * $urandom_range(0, 2);
      random_phase(ITEMS_PER_PHASE);
    end

    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d items under %0d register settings, one long result hold-off.",
             items_sent, settings_applied);
    $display("Model totals: %0d TLB hits, %0d misses, %0d fills.",
             hit_count, miss_count, fill_count);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side: random stall bursts, one long hold-off so the block backs
  // up into its input, and a field-by-field compare of every result taken.
  // ---------------------------------------------------------------------------
  task automatic check_result(out_item_t got);
    out_item_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      $error("result with no item outstanding: %p", got);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    if (got.result_address !== want.result_address) begin
      $error("result_address: expected %h, got %h", want.result_address, got.result_address);
      mismatches++;
    end
    if (got.tlb_hit !== want.tlb_hit) begin
      $error("tlb_hit: expected %b, got %b", want.tlb_hit, got.tlb_hit);
      mismatches++;
    end
    if (got.table_hit !== want.table_hit) begin
      $error("table_hit: expected %b, got %b", want.table_hit, got.table_hit);
      mismatches++;
    end
    if (got.hit_total !== want.hit_total) begin
      $error("hit_total: expected %0d, got %0d", want.hit_total, got.hit_total);
      mismatches++;
    end
    if (got.miss_total !== want.miss_total) begin
      $error("miss_total: expected %0d, got %0d", want.miss_total, got.miss_total);
      mismatches++;
    end
  endtask

  initial begin : take_results
    int unsigned hold;
    bit          long_hold_done;
    hold           = 0;
    long_hold_done = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (rsp_valid && rsp_ready) check_result(rsp);
      if (hold != 0) begin
        hold--;
      end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        hold           = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if (take_gap_pct != 0 && $urandom_range(0, 99) < take_gap_pct) begin
        hold = $urandom_range(1, 9);
      end
      rsp_ready <= (hold == 0);
    end
  end

  // Watchdog: far beyond the slowest legal run (every fill a full LRU scan,
  // every gap and stall at its longest, plus the long hold-off).
  initial begin : watchdog
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* sim.f */
src/fat_pkg.sv
src/fat_front.sv
src/fat_queue.sv
src/fat_back.sv
src/fully_assoc_tlb_lru_top.sv
bench/fully_assoc_tlb_lru_top_tb.sv
